/* rtl/bac_pkg.sv */
// Shared types and constants for the block autocorrelation engine.
package bac_pkg;

  localparam int LAG_BITS  = 5;
  localparam int ACC_BITS  = 48;
  localparam int CFG_BITS  = 5;
  localparam logic [CFG_BITS-1:0] HIGHEST_LAG_RESET = 5'd16;

  // Per-cycle controls broadcast from the controller to every cell.
  typedef struct packed {
    logic take;       // sample transfer this cycle
    logic block_end;  // transferred sample closes the block
    logic acc_valid;  // product stage holds a valid product
    logic snap;       // product stage holds the block's last product
    logic shift;      // result transfer, shadow chain moves one cell down
  } cell_ctrl_t;

endpackage

/* rtl/bac_ifs.sv */
// Stream interfaces: sample input and correlation result output.
interface bac_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          block_end;

  modport source (output valid, sample, block_end, input ready);
  modport sink   (input valid, sample, block_end, output ready);
endinterface

interface bac_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [bac_pkg::LAG_BITS-1:0]           lag;
  logic signed [bac_pkg::ACC_BITS-1:0]    correlation;
  logic                                   final_lag;

  modport source (output valid, lag, correlation, final_lag, input ready);
  modport sink   (input valid, lag, correlation, final_lag, output ready);
endinterface

/* rtl/block_autocorrelation_top.sv */
// Top level of the block autocorrelation engine: config register, controller, cell chain.
//
//  channel  dir  handshake          payload
//  samp_i   in   valid/ready        sample, block_end
//  corr_o   out  valid/ready        lag, correlation, final_lag
//  cfg      in   cfg_we_i (no wait) cfg_data_i = highest_lag
//
// One sample per cycle unless a closing sample is held off; each lag cell does one multiply-accumulate per sample.
// Results of a block are snapped into the shadow chain once its closing product is summed, and leave one per
// cycle while corr_o is ready, from the shadow chain while the next block streams in.
// A closing sample is held off until the previous block's results are all out.
// Reset clears the delay taps and sums and sets highest_lag to 16.
module block_autocorrelation_top #(
  parameter int MAX_LAG     = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bac_pkg::CFG_BITS-1:0] cfg_data_i,
  bac_in_if.sink                       samp_i,
  bac_out_if.source                    corr_o
);

  localparam int NumCells = MAX_LAG + 1;
  localparam int CntW     = $clog2(MAX_LAG + 1);

  logic [bac_pkg::CFG_BITS-1:0]    highest_lag_q;
  bac_pkg::cell_ctrl_t             ctrl_w;
  logic [CntW-1:0]                 lag_w;
  logic signed [SAMPLE_BITS-1:0]   tap_w [NumCells+1];
  logic signed [bac_pkg::ACC_BITS-1:0] shadow_w [NumCells+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      highest_lag_q <= bac_pkg::HIGHEST_LAG_RESET;
    end else if (cfg_we_i) begin
      highest_lag_q <= cfg_data_i;
    end
  end

  bac_ctrl #(
    .MAX_LAG (MAX_LAG)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .highest_lag_i  (highest_lag_q),
    .in_valid_i     (samp_i.valid),
    .in_block_end_i (samp_i.block_end),
    .in_ready_o     (samp_i.ready),
    .out_valid_o    (corr_o.valid),
    .out_ready_i    (corr_o.ready),
    .lag_o          (lag_w),
    .final_o        (corr_o.final_lag),
    .ctrl_o         (ctrl_w)
  );

  // cell 0 squares the new sample; cell d multiplies by the tap of cell d-1
  assign tap_w[0]           = samp_i.sample;
  assign shadow_w[NumCells] = '0;

  for (genvar d = 0; d < NumCells; d++) begin : g_cell
    bac_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl_w),
      .x_i      (samp_i.sample),
      .tap_i    (tap_w[d]),
      .tap_o    (tap_w[d+1]),
      .shadow_i (shadow_w[d+1]),
      .shadow_o (shadow_w[d])
    );
  end

  assign corr_o.lag         = bac_pkg::LAG_BITS'(lag_w);
  assign corr_o.correlation = shadow_w[0];

endmodule

/* rtl/bac_cell.sv */
// One lag cell: delay tap, registered product, saturating accumulator, shadow result.
module bac_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bac_pkg::cell_ctrl_t                 ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0]       x_i,
  input  logic signed [SAMPLE_BITS-1:0]       tap_i,
  output logic signed [SAMPLE_BITS-1:0]       tap_o,
  input  logic signed [bac_pkg::ACC_BITS-1:0] shadow_i,
  output logic signed [bac_pkg::ACC_BITS-1:0] shadow_o
);

  localparam int ProdW = 2 * SAMPLE_BITS;
  localparam int AccW  = bac_pkg::ACC_BITS;

  logic signed [SAMPLE_BITS-1:0] tap_q;
  logic signed [ProdW-1:0]       prod_q, prod_d;
  logic signed [AccW-1:0]        acc_q;
  logic signed [AccW-1:0]        shadow_q;
  logic signed [AccW:0]          sum_w;
  logic signed [AccW-1:0]        sat_w;

  assign prod_d = x_i * tap_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.take) begin
      prod_q <= prod_d;
    end
  end

  // tap moves one cell along per sample; a closing sample empties the line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else if (ctrl_i.take) begin
      tap_q <= ctrl_i.block_end ? '0 : tap_i;
    end
  end

  assign sum_w = {acc_q[AccW-1], acc_q} + {{(AccW + 1 - ProdW){prod_q[ProdW-1]}}, prod_q};

  always_comb begin
    if (sum_w[AccW] != sum_w[AccW-1]) begin
      sat_w = sum_w[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      sat_w = sum_w[AccW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_valid) begin
      acc_q <= ctrl_i.snap ? '0 : sat_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.snap) begin
      shadow_q <= sat_w;
    end else if (ctrl_i.shift) begin
      shadow_q <= shadow_i;
    end
  end

  assign tap_o    = tap_q;
  assign shadow_o = shadow_q;

endmodule

/* rtl/bac_ctrl.sv */
// Controller: product-stage tracking, input hold-off and result sequencing.
module bac_ctrl #(
  parameter int MAX_LAG = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [bac_pkg::CFG_BITS-1:0]    highest_lag_i,
  input  logic                            in_valid_i,
  input  logic                            in_block_end_i,
  output logic                            in_ready_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [$clog2(MAX_LAG+1)-1:0]    lag_o,
  output logic                            final_o,
  output bac_pkg::cell_ctrl_t             ctrl_o
);

  localparam int CntW = $clog2(MAX_LAG + 1);

  logic            v1_q, e1_q;
  logic            drain_q, drain_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] top_q, top_d;
  logic [CntW-1:0] top_w;
  logic            take_w, shift_w, last_w;

  assign top_w = (32'(highest_lag_i) > 32'(MAX_LAG)) ? CntW'(MAX_LAG) : CntW'(highest_lag_i);

  // a closing sample waits until the previous block's results are out of the shadow chain
  assign in_ready_o = !(in_block_end_i && (e1_q || drain_q));
  assign take_w     = in_valid_i && in_ready_o;
  assign shift_w    = drain_q && out_ready_i;
  assign last_w     = (cnt_q == top_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      e1_q <= 1'b0;
    end else begin
      v1_q <= take_w;
      e1_q <= take_w && in_block_end_i;
    end
  end

  always_comb begin
    drain_d = drain_q;
    cnt_d   = cnt_q;
    top_d   = top_q;
    if (e1_q) begin
      drain_d = 1'b1;
      cnt_d   = '0;
      top_d   = top_w;
    end else if (shift_w) begin
      if (last_w) begin
        drain_d = 1'b0;
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
      cnt_q   <= '0;
      top_q   <= '0;
    end else begin
      drain_q <= drain_d;
      cnt_q   <= cnt_d;
      top_q   <= top_d;
    end
  end

  assign out_valid_o = drain_q;
  assign lag_o       = cnt_q;
  assign final_o     = last_w;

  assign ctrl_o.take      = take_w;
  assign ctrl_o.block_end = in_block_end_i;
  assign ctrl_o.acc_valid = v1_q;
  assign ctrl_o.snap      = e1_q;
  assign ctrl_o.shift     = shift_w;

endmodule

/* tb/tb.sv */
// Self-checking testbench for block_autocorrelation_top: lag sums, lag settings, back-pressure.
module tb;

  localparam int     TAPS        = 16;
  localparam int     CYCLE_LIMIT = 2_000_000;
  localparam int     RAND_ITEMS  = 420;
  localparam int     HOLD_CYCLES = 400;
  localparam longint SUM_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_MIN     = -SUM_MAX - 1;
  localparam logic signed [15:0] S_MAX = 16'sh7FFF;
  localparam logic signed [15:0] S_MIN = 16'sh8000;

  typedef struct {
    logic [bac_pkg::LAG_BITS-1:0]        lag;
    logic signed [bac_pkg::ACC_BITS-1:0] corr;
    logic                                fin;
  } corr_t;

  class lag_sum_tracker;
    logic signed [15:0]           taps [TAPS];
    longint                       sums [TAPS+1];
    logic [bac_pkg::CFG_BITS-1:0] top_lag;
    corr_t                        expected_corr [$];
    int                           errors;
    int                           checked;
    int                           clamps;

    function new();
      clear();
      top_lag = bac_pkg::HIGHEST_LAG_RESET;
      errors  = 0;
      checked = 0;
      clamps  = 0;
    endfunction

    function void clear();
      foreach (taps[i]) taps[i] = '0;
      foreach (sums[i]) sums[i] = 0;
    endfunction

    function void set_highest_lag(logic [bac_pkg::CFG_BITS-1:0] v);
      top_lag = v;
    endfunction

    function longint clamp_add(longint a, longint p);
      longint s;
      s = a + p;
      if (s > SUM_MAX) begin
        clamps++;
        return SUM_MAX;
      end
      if (s < SUM_MIN) begin
        clamps++;
        return SUM_MIN;
      end
      return s;
    endfunction

    // called on every accepted sample transfer
    function void take_sample(logic signed [15:0] x, logic fin);
      int    lim;
      corr_t r;
      sums[0] = clamp_add(sums[0], longint'(x) * longint'(x));
      for (int d = 1; d <= TAPS; d++)
        sums[d] = clamp_add(sums[d], longint'(x) * longint'(taps[d-1]));
      for (int d = TAPS - 1; d > 0; d--) taps[d] = taps[d-1];
      taps[0] = x;
      if (!fin) return;
      lim = (top_lag > TAPS) ? TAPS : int'(top_lag);
      for (int d = 0; d <= lim; d++) begin
        r.lag  = d[bac_pkg::LAG_BITS-1:0];
        r.corr = sums[d][bac_pkg::ACC_BITS-1:0];
        r.fin  = (d == lim);
        expected_corr.push_back(r);
      end
      clear();
    endfunction

    function void check_result(logic [bac_pkg::LAG_BITS-1:0] lag,
                               logic signed [bac_pkg::ACC_BITS-1:0] corr,
                               logic fin);
      corr_t w;
      checked++;
      if (expected_corr.size() == 0) begin
        errors++;
        if (errors <= 20)
          $display("%0t: unexpected result lag %0d corr %0d final %0b", $time, lag, corr, fin);
        return;
      end
      w = expected_corr.pop_front();
      if (lag !== w.lag || corr !== w.corr || fin !== w.fin) begin
        errors++;
        if (errors <= 20)
          $display("%0t: mismatch: exp lag %0d corr %0d fin %0b, got lag %0d corr %0d fin %0b",
                   $time, w.lag, w.corr, w.fin, lag, corr, fin);
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [bac_pkg::CFG_BITS-1:0] cfg_data;
  logic                         steady;
  logic                         hold_req;
  int                           hold_left;
  int                           cycles;
  int                           n_samples;
  int                           n_blocks;
  int                           n_cfg;

  lag_sum_tracker board;

  bac_in_if #(.SAMPLE_BITS(16)) samp ();
  bac_out_if                    corr ();

  block_autocorrelation_top #(
    .MAX_LAG    (16),
    .SAMPLE_BITS(16)
  ) uut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data),
    .samp_i    (samp),
    .corr_o    (corr)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off once results are waiting
  initial corr.ready = 1'b0;
  always @(negedge clk) begin
    if (hold_req && corr.valid) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      corr.ready <= 1'b0;
      hold_left--;
    end else begin
      corr.ready <= steady || ($urandom_range(99) >= 28);
    end
  end

  always @(posedge clk) begin
    if (rst_n && corr.valid && corr.ready)
      board.check_result(corr.lag, corr.correlation, corr.final_lag);
  end

  function automatic logic signed [15:0] pick_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0:       return S_MAX;
      1:       return S_MIN;
      2, 3:    return 16'(int'($urandom_range(200)) - 100);
      default: return r[15:0];
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic push_sample(logic signed [15:0] s, logic fin);
    while (!steady && $urandom_range(99) < 28) begin
      samp.valid <= 1'b0;
      @(negedge clk);
    end
    samp.valid     <= 1'b1;
    samp.sample    <= s;
    samp.block_end <= fin;
    @(posedge clk);
    while (!samp.ready) @(posedge clk);
    board.take_sample(s, fin);
    n_samples++;
    if (fin) n_blocks++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    samp.valid <= 1'b0;
    while (board.expected_corr.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_highest_lag(logic [bac_pkg::CFG_BITS-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    board.set_highest_lag(v);
    n_cfg++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_block(int len, bit split);
    for (int i = 0; i < len; i++) begin
      // register change in the middle of a block, with the block idle
      if (split && i == len / 2 && i > 0) begin
        wait_drain();
        write_highest_lag(5'($urandom_range(31)));
      end
      push_sample(pick_sample(), i == len - 1);
    end
  endtask

  initial begin
    logic signed [15:0] extremes [8];
    int                 start;
    int                 len;

    extremes  = '{S_MAX, S_MIN, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh5555, 16'shAAAA, S_MAX};
    board     = new();
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_data  = '0;
    steady    = 1'b0;
    hold_req  = 1'b0;
    hold_left = 0;
    cycles    = 0;
    n_samples = 0;
    n_blocks  = 0;
    n_cfg     = 0;
    samp.valid     = 1'b0;
    samp.sample    = '0;
    samp.block_end = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: extremes at the reset lag setting, then a one-sample block
    foreach (extremes[i]) push_sample(extremes[i], i == 7);
    push_sample(S_MIN, 1'b1);

    wait_drain();
    write_highest_lag(5'd0);
    push_sample(16'sd100, 1'b0);
    push_sample(-16'sd200, 1'b0);
    push_sample(16'sd300, 1'b1);

    // register changed mid-block; 31 is above the lag count and clamps to 16
    wait_drain();
    write_highest_lag(5'd5);
    push_sample(S_MIN, 1'b0);
    push_sample(S_MIN, 1'b0);
    wait_drain();
    write_highest_lag(5'd31);
    push_sample(S_MAX, 1'b1);

    wait_drain();
    write_highest_lag(5'd17);
    for (int i = 1; i <= 4; i++) push_sample(16'(i), i == 4);

    // random blocks
    wait_drain();
    write_highest_lag(5'($urandom_range(31)));
    hold_req = 1'b1;
    start    = n_samples;
    for (int b = 0; n_samples - start < RAND_ITEMS; b++) begin
      steady = (b >= 6 && b < 12);
      if ($urandom_range(99) < 20) begin
        wait_drain();
        write_highest_lag(5'($urandom_range(31)));
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 25) : $urandom_range(24, 1);
      random_block(len, $urandom_range(9) == 0);
    end
    steady = 1'b0;
    samp.valid <= 1'b0;

    while (board.expected_corr.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("run covered %0d samples in %0d blocks, %0d lag settings, %0d results checked",
             n_samples, n_blocks, n_cfg, board.checked);
    $display("%0d clamped additions, one %0d-cycle result hold-off", board.clamps, HOLD_CYCLES);
    if (board.errors == 0 && board.expected_corr.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
